// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// clocked property checks, with and without a reset qualifier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is asserted
`define PNC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that also holds across reset
`define PNC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pnc_pkg.sv =====
// ----------------------------------------------------------------------------
// pnc_pkg
// types, register map, reason codes and glitch limits of the classifier
// ----------------------------------------------------------------------------
package pnc_pkg;

    localparam int AREA_W        = 28;
    localparam int ADDR_W        = 5;
    localparam int NUM_DETECTORS = 30;
    localparam int GLITCH_ENTRIES = 30;

    typedef logic signed [AREA_W-1:0] area_t;

    // register map, index = paddr / 4
    typedef enum logic [2:0] {
        REG_AREA_THR  = 3'd0,
        REG_SIGMA     = 3'd1,
        REG_RMS_FLOOR = 3'd2,
        REG_WIN_FIRST = 3'd3,
        REG_WIN_END   = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        RSN_SIGNAL = 3'd0,
        RSN_FLAT   = 3'd1,
        RSN_AREA   = 3'd2,
        RSN_PEAK   = 3'd3,
        RSN_EARLY  = 3'd4,
        RSN_GLITCH = 3'd5,
        RSN_REPEAT = 3'd6
    } reason_t;

    localparam logic [1:0] KIND_CHARGE = 2'd0;
    localparam logic [1:0] KIND_PHONON = 2'd1;

    localparam logic signed [31:0] AREA_THR_RST  = 32'sd2000;
    localparam logic [7:0]         SIGMA_RST     = 8'd48;
    localparam logic [15:0]        RMS_FLOOR_RST = 16'd16;
    localparam logic [11:0]        WIN_FIRST_RST = 12'd499;
    localparam logic [12:0]        WIN_END_RST   = 13'd700;

    typedef struct packed {
        logic signed [31:0] area_threshold;
        logic [7:0]         sigma_gain;
        logic [15:0]        rms_floor;
        logic [11:0]        window_first;
        logic [12:0]        window_end;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic [1:0]         req_type;
        logic [15:0]        pulse_rms;
        logic signed [15:0] pulse_max;
        logic [4:0]         detector_index;
    } item_t;

    typedef struct packed {
        area_t total_area;
        area_t window_area;
        logic  peak_valid;
    } stats_t;

    // per-detector glitch limits, detector n at entry n-1
    localparam logic [12:0] GLITCH_LIMIT [GLITCH_ENTRIES] = '{
        13'd4000, 13'd5000, 13'd6000, 13'd1800, 13'd5000, 13'd2000,
        13'd3000, 13'd4000, 13'd2600, 13'd3000, 13'd2000, 13'd2800,
        13'd3000, 13'd5000, 13'd3000, 13'd5000, 13'd5000, 13'd5000,
        13'd3000, 13'd5000, 13'd3000, 13'd5000, 13'd5000, 13'd5000,
        13'd5000, 13'd5000, 13'd3000, 13'd5000, 13'd5000, 13'd5000
    };

    // saturating add of one sample into an area sum
    function automatic area_t sat_add(area_t a, logic signed [15:0] s);
        logic signed [AREA_W:0] sum;
        area_t                  res;
        sum = {a[AREA_W-1], a} + {{(AREA_W + 1 - 16){s[15]}}, s};
        if (sum[AREA_W] != sum[AREA_W-1]) begin
            res = sum[AREA_W] ? {1'b1, {(AREA_W - 1){1'b0}}} : {1'b0, {(AREA_W - 1){1'b1}}};
        end else begin
            res = sum[AREA_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/pulse_noise_classifier.sv =====
// ----------------------------------------------------------------------------
// pulse_noise_classifier
// per-trace noise classification of charge and phonon pulses
// ----------------------------------------------------------------------------
// usage:
//  - input stream carries one trace sample per transaction; tlast marks the
//    final sample, tuser gives the channel kind (charge, phonon, other)
//  - the result stream gives one transaction per trace, on its last sample:
//    the noise flag and a reason code
//  - thresholds and the peak window live in an apb register file; write them
//    only while no trace is in flight
//  - throughput is one sample per cycle while the result register can take a
//    finished trace, set by the single add/compare pass of the accumulator
//    between the input register and the state registers
//  - a last sample reaches m_tvalid through the input register, then the result register
//  - reset clears the trace sums and the remembered decision, empties both pipeline
//    registers, and loads the register defaults
//  - when the receiver stalls, a waiting result holds in the result register;
//    non-last samples keep flowing, a second last sample waits in the input
//    register and s_tready drops only then
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_noise_classifier #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // sample, pulse_rms, pulse_max, detector_index
    input  logic        s_tlast,
    input  logic [1:0]  s_tuser,   // req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // is_noise, reason
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pnc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    cfg_t             cfg;
    item_t            item_reg, item_next;
    logic             in_valid_reg, in_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             noise_reg, noise_next;
    reason_t          reason_reg, reason_next;
    logic             out_free, stage_fire, commit, s_fire;
    stats_t           stats_upd;
    logic [CNT_W-1:0] peak_pos_upd;
    logic             dec_noise;
    reason_t          dec_reason;

    // the input register empties whenever its sample has somewhere to go
    assign out_free   = !out_valid_reg || m_tready;
    assign stage_fire = in_valid_reg && (!item_reg.last || out_free);
    assign commit     = stage_fire && item_reg.last;
    assign s_tready   = !in_valid_reg || stage_fire;
    assign s_fire     = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, reason_reg, noise_reg};

    pnc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pnc_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W)
    ) u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (stage_fire),
        .item         (item_reg),
        .cfg          (cfg),
        .stats_upd    (stats_upd),
        .peak_pos_upd (peak_pos_upd)
    );

    pnc_decide #(
        .CNT_W (CNT_W)
    ) u_decide (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .commit   (commit),
        .item     (item_reg),
        .cfg      (cfg),
        .stats    (stats_upd),
        .peak_pos (peak_pos_upd),
        .is_noise (dec_noise),
        .reason   (dec_reason)
    );

    // input register
    always_comb begin
        item_next     = item_reg;
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            item_next.sample         = $signed(s_tdata[15:0]);
            item_next.pulse_rms      = s_tdata[31:16];
            item_next.pulse_max      = $signed(s_tdata[47:32]);
            item_next.detector_index = s_tdata[52:48];
            item_next.last           = s_tlast;
            item_next.req_type       = s_tuser;
            in_valid_next            = 1'b1;
        end else if (stage_fire) begin
            in_valid_next = 1'b0;
        end
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        noise_next     = noise_reg;
        reason_next    = reason_reg;
        if (commit) begin
            out_valid_next = 1'b1;
            noise_next     = dec_noise;
            reason_next    = dec_reason;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        noise_reg  <= noise_next;
        reason_reg <= reason_next;
    end

    // a finished trace always lands in the result register
    `PNC_ASSERT(a_commit_lands, aclk, aresetn, commit |=> out_valid_reg, "trace result lost")
    // a sample that cannot advance stays put
    `PNC_ASSERT(a_hold_input, aclk, aresetn, (in_valid_reg && !stage_fire) |=> in_valid_reg, "stalled sample dropped")
    // a signal verdict never carries the noise flag
    `PNC_ASSERT(a_signal_clean, aclk, aresetn, (out_valid_reg && reason_reg == RSN_SIGNAL) |-> !noise_reg, "signal reason with noise flag")
    // reset empties both pipeline registers
    `PNC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!in_valid_reg && !out_valid_reg), "pipeline not empty after reset")

endmodule

// ===== hw/rtl/pnc_cfg.sv =====
// ----------------------------------------------------------------------------
// pnc_cfg
// apb register file holding thresholds and window bounds
// ----------------------------------------------------------------------------
module pnc_cfg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pnc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output pnc_pkg::cfg_t             cfg
);
    import pnc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_AREA_THR:  cfg_next.area_threshold = $signed(pwdata);
                REG_SIGMA:     cfg_next.sigma_gain     = pwdata[7:0];
                REG_RMS_FLOOR: cfg_next.rms_floor      = pwdata[15:0];
                REG_WIN_FIRST: cfg_next.window_first   = pwdata[11:0];
                REG_WIN_END:   cfg_next.window_end     = pwdata[12:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_AREA_THR:  prdata = cfg_reg.area_threshold;
            REG_SIGMA:     prdata = {24'd0, cfg_reg.sigma_gain};
            REG_RMS_FLOOR: prdata = {16'd0, cfg_reg.rms_floor};
            REG_WIN_FIRST: prdata = {20'd0, cfg_reg.window_first};
            REG_WIN_END:   prdata = {19'd0, cfg_reg.window_end};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.area_threshold <= AREA_THR_RST;
            cfg_reg.sigma_gain     <= SIGMA_RST;
            cfg_reg.rms_floor      <= RMS_FLOOR_RST;
            cfg_reg.window_first   <= WIN_FIRST_RST;
            cfg_reg.window_end     <= WIN_END_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/pnc_accum.sv =====
// ----------------------------------------------------------------------------
// pnc_accum
// per-trace sample count, area sums and window peak tracking
// ----------------------------------------------------------------------------
module pnc_accum #(
    parameter int MAX_SAMPLES = 4096,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  pnc_pkg::item_t         item,
    input  pnc_pkg::cfg_t          cfg,
    output pnc_pkg::stats_t        stats_upd,
    output logic [CNT_W-1:0]       peak_pos_upd
);
    import pnc_pkg::*;

    localparam int CMP_W = (CNT_W > 13) ? CNT_W : 13;

    logic [CNT_W-1:0]   count_reg, count_next, count_upd;
    area_t              total_reg, total_next;
    area_t              win_reg, win_next;
    logic signed [15:0] peak_val_reg, peak_val_next, peak_val_upd;
    logic [CNT_W-1:0]   peak_pos_reg, peak_pos_next;
    logic               peak_valid_reg, peak_valid_next;
    logic [CMP_W-1:0]   idx_ext;
    logic               in_range, in_win;

    assign idx_ext  = CMP_W'(count_reg);
    assign in_range = count_reg < CNT_W'(MAX_SAMPLES);
    assign in_win   = (idx_ext >= CMP_W'(cfg.window_first)) &&
                      (idx_ext <  CMP_W'(cfg.window_end));

    // state after taking this sample
    always_comb begin
        count_upd    = count_reg;
        stats_upd    = '{total_area: total_reg, window_area: win_reg,
                         peak_valid: peak_valid_reg};
        peak_val_upd = peak_val_reg;
        peak_pos_upd = peak_pos_reg;
        if (in_range) begin
            count_upd            = count_reg + 1'b1;
            stats_upd.total_area = sat_add(total_reg, item.sample);
            if (in_win) begin
                stats_upd.window_area = sat_add(win_reg, item.sample);
                if (!peak_valid_reg || (item.sample > peak_val_reg)) begin
                    peak_val_upd         = item.sample;
                    peak_pos_upd         = count_reg;
                    stats_upd.peak_valid = 1'b1;
                end
            end
        end
    end

    // the last sample closes the trace
    always_comb begin
        count_next      = count_reg;
        total_next      = total_reg;
        win_next        = win_reg;
        peak_val_next   = peak_val_reg;
        peak_pos_next   = peak_pos_reg;
        peak_valid_next = peak_valid_reg;
        if (advance) begin
            if (item.last) begin
                count_next      = '0;
                total_next      = '0;
                win_next        = '0;
                peak_val_next   = '0;
                peak_pos_next   = '0;
                peak_valid_next = 1'b0;
            end else begin
                count_next      = count_upd;
                total_next      = stats_upd.total_area;
                win_next        = stats_upd.window_area;
                peak_val_next   = peak_val_upd;
                peak_pos_next   = peak_pos_upd;
                peak_valid_next = stats_upd.peak_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            total_reg      <= '0;
            win_reg        <= '0;
            peak_val_reg   <= '0;
            peak_pos_reg   <= '0;
            peak_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            total_reg      <= total_next;
            win_reg        <= win_next;
            peak_val_reg   <= peak_val_next;
            peak_pos_reg   <= peak_pos_next;
            peak_valid_reg <= peak_valid_next;
        end
    end

endmodule

// ===== hw/rtl/pnc_decide.sv =====
// ----------------------------------------------------------------------------
// pnc_decide
// noise tests on the finished trace and the remembered last decision
// ----------------------------------------------------------------------------
module pnc_decide #(
    parameter int CNT_W = 13
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              commit,
    input  pnc_pkg::item_t    item,
    input  pnc_pkg::cfg_t     cfg,
    input  pnc_pkg::stats_t   stats,
    input  logic [CNT_W-1:0]  peak_pos,
    output logic              is_noise,
    output pnc_pkg::reason_t  reason
);
    import pnc_pkg::*;

    localparam int CMP_W = (CNT_W > 12) ? CNT_W : 12;

    logic               last_dec_reg, last_dec_next;
    logic signed [25:0] peak_lhs, peak_rhs;
    logic [23:0]        sig_rms;
    logic signed [23:0] mx100, lim_ext;
    logic signed [28:0] mx60, win_ext;
    logic [4:0]         det_m1;
    logic               det_ok;
    logic               flat, small_area, low_peak, early, glitch;
    reason_t            phonon_rsn;

    assign sig_rms  = item.pulse_rms * cfg.sigma_gain;
    assign peak_lhs = {{2{item.pulse_max[15]}}, item.pulse_max, 8'd0};
    assign peak_rhs = $signed({2'b00, sig_rms});
    assign mx100    = 24'(item.pulse_max) * 24'sd100;
    assign mx60     = 29'(item.pulse_max) * 29'sd60;
    assign win_ext  = 29'(stats.window_area);
    assign det_m1   = item.detector_index - 5'd1;
    assign det_ok   = (item.detector_index != 5'd0) &&
                      (7'(item.detector_index) <= 7'(GLITCH_ENTRIES)) &&
                      (7'(item.detector_index) <= 7'(NUM_DETECTORS));
    assign lim_ext  = det_ok ? $signed({11'd0, GLITCH_LIMIT[det_m1]}) : 24'sd0;

    assign flat       = item.pulse_rms < cfg.rms_floor;
    assign small_area = 32'(stats.total_area) < cfg.area_threshold;
    assign low_peak   = peak_lhs < peak_rhs;
    assign early      = !stats.peak_valid ||
                        (CMP_W'(peak_pos) <= CMP_W'(cfg.window_first));
    assign glitch     = det_ok && (mx100 > lim_ext) && (win_ext < mx60);

    always_comb begin
        priority if (flat)       phonon_rsn = RSN_FLAT;
        else if (small_area)     phonon_rsn = RSN_AREA;
        else if (low_peak)       phonon_rsn = RSN_PEAK;
        else if (early)          phonon_rsn = RSN_EARLY;
        else if (glitch)         phonon_rsn = RSN_GLITCH;
        else                     phonon_rsn = RSN_SIGNAL;
    end

    always_comb begin
        last_dec_next = last_dec_reg;
        unique case (item.req_type)
            KIND_CHARGE: begin
                reason   = flat ? RSN_FLAT : RSN_SIGNAL;
                is_noise = flat;
            end
            KIND_PHONON: begin
                reason   = phonon_rsn;
                is_noise = (phonon_rsn != RSN_SIGNAL);
            end
            default: begin
                reason   = RSN_REPEAT;
                is_noise = last_dec_reg;
            end
        endcase
        if (commit) begin
            last_dec_next = is_noise;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_dec_reg <= 1'b0;
        end else begin
            last_dec_reg <= last_dec_next;
        end
    end

endmodule
